>>> rtl/ilir_pkg.sv
package ilir_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned POS_W  = 7;
	localparam int unsigned CNT_W  = 7;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	// per-cell control for one accepted item
	typedef struct packed {
		logic ins;  // insert takes effect this cycle
		logic rem;  // remove takes effect this cycle
		logic eq;   // this cell sits at the item's position
		logic gt;   // this cell sits above the item's position
	} cell_ctrl_t;

endpackage

>>> rtl/indexed_list_insert_remove.sv
// Ordered list with insert and remove at an index, kept in a row of shifting cells.
// Done rises in the cycle after start is accepted and stays high for one cycle.
// Throughput: one item per cycle; busy stays low since all cells shift in parallel.
// Reset: arst_n clears the entry count and the result strobe; cell contents stay
// undefined until written, and a remove only takes out a cell below the count.
// The receiver cannot stall: each result is shown for exactly one cycle.
module indexed_list_insert_remove
	import ilir_pkg::*;
#(
	parameter int unsigned CAPACITY = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      cmd,
	input  logic [POS_W-1:0]          position,
	input  logic signed [DATA_W-1:0]  value,
	output logic                      done,
	output logic [1:0]                status,
	output logic signed [DATA_W-1:0]  removed_value,
	output logic [CNT_W-1:0]          count
);

	// internal count holds 0..CAPACITY; compares run in a width that fits
	// both the count and the position port
	localparam int unsigned IC_W  = $clog2(CAPACITY + 1);
	localparam int unsigned CMP_W = (IC_W > POS_W) ? IC_W : POS_W;

	logic [IC_W-1:0]    count_q;
	logic [IC_W-1:0]    count_d;
	logic [CMP_W-1:0]   count_ext;
	logic [CMP_W-1:0]   pos_ext;
	logic               accept;
	logic               ins_ok;
	logic               rem_ok;
	status_t            status_d;

	logic               done_q;
	status_t            status_q;
	logic [DATA_W-1:0]  removed_q;
	logic [DATA_W-1:0]  removed_d;

	logic [DATA_W-1:0]  cell_data [CAPACITY];
	logic [DATA_W-1:0]  cell_tap  [CAPACITY];

	assign accept    = start && !busy;
	assign count_ext = CMP_W'(count_q);
	assign pos_ext   = CMP_W'(position);

	// check the command against the count: full and empty come before range
	always_comb begin
		status_d = ST_OK;
		ins_ok   = 1'b0;
		rem_ok   = 1'b0;
		case (cmd_t'(cmd))
			CMD_INSERT: begin
				if (count_ext == CMP_W'(CAPACITY)) begin
					status_d = ST_FULL;
				end else if (pos_ext > count_ext) begin
					status_d = ST_RANGE;
				end else begin
					ins_ok = accept;
				end
			end
			CMD_REMOVE: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else if (pos_ext >= count_ext) begin
					status_d = ST_RANGE;
				end else begin
					rem_ok = accept;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_comb begin
		count_d = count_q;
		if (ins_ok) begin
			count_d = count_q + IC_W'(1);
		end else if (rem_ok) begin
			count_d = count_q - IC_W'(1);
		end
	end

	// row of cells: each compares its own place with the position
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CMP_W-1:0] IDX = CMP_W'(i);
		cell_ctrl_t        ctrl;
		logic [DATA_W-1:0] left_data;
		logic [DATA_W-1:0] right_data;

		assign ctrl.ins = ins_ok;
		assign ctrl.rem = rem_ok;
		assign ctrl.eq  = (IDX == pos_ext);
		assign ctrl.gt  = (IDX > pos_ext);

		if (i == 0) begin : g_first
			assign left_data = '0;
		end else begin : g_mid_l
			assign left_data = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_data = '0;
		end else begin : g_mid_r
			assign right_data = cell_data[i+1];
		end

		ilir_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.ins_value  (value),
			.left_data  (left_data),
			.right_data (right_data),
			.data       (cell_data[i]),
			.tap        (cell_tap[i])
		);
	end

	// only the cell at the position drives its tap, so merge the taps by OR
	always_comb begin
		removed_d = '0;
		for (int unsigned k = 0; k < CAPACITY; k++) begin
			removed_d = removed_d | cell_tap[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= accept;
		end
	end

	// hold the result fields for the strobe cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= status_d;
			removed_q <= removed_d;
		end
	end

	assign busy          = 1'b0;
	assign done          = done_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	// count register already shows the count after the item
	assign count         = count_ext[CNT_W-1:0];

endmodule

>>> rtl/ilir_cell.sv
module ilir_cell
	import ilir_pkg::*;
(
	input  logic                clk,
	input  cell_ctrl_t          ctrl,
	input  logic [DATA_W-1:0]   ins_value,
	input  logic [DATA_W-1:0]   left_data,
	input  logic [DATA_W-1:0]   right_data,
	output logic [DATA_W-1:0]   data,
	output logic [DATA_W-1:0]   tap
);

	logic [DATA_W-1:0] data_q;

	// take from the lower neighbor or new value on insert, upper on remove
	always_ff @(posedge clk) begin
		if (ctrl.ins && ctrl.gt) begin
			data_q <= left_data;
		end else if (ctrl.ins && ctrl.eq) begin
			data_q <= ins_value;
		end else if (ctrl.rem && (ctrl.gt || ctrl.eq)) begin
			data_q <= right_data;
		end
	end

	assign data = data_q;
	assign tap  = (ctrl.rem && ctrl.eq) ? data_q : '0;

endmodule
